// ----- rtl/three_level_round_robin_scheduler_top_defines.svh -----
// ----------------------------------------------------------------------------
// Three-level round-robin scheduler assertion macros
// Shared concurrent assertion forms for the scheduler checker.
// ----------------------------------------------------------------------------
`ifndef THREE_LEVEL_ROUND_ROBIN_SCHEDULER_TOP_DEFINES_SVH
`define THREE_LEVEL_ROUND_ROBIN_SCHEDULER_TOP_DEFINES_SVH

// Assertion on an explicit clock with an explicit disable condition.
`define TRRS_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion on the block clock, disabled while reset is high.
`define TRRS_ASSERT(label, prop, msg) `TRRS_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

// ----- rtl/trrs_pkg.sv -----
// ----------------------------------------------------------------------------
// Three-level round-robin scheduler package
// Codes, widths and shared types of the thread scheduler.
// ----------------------------------------------------------------------------
package trrs_pkg;

   localparam int THREADS_DEFAULT = 16;

   localparam int FUNC_W  = 3;
   localparam int TID_W   = 4;
   localparam int INDEX_W = 4;
   localparam int COUNT_W = 5;
   localparam int ADDR_W  = 32;
   localparam int WAIT_W  = 16;

   localparam logic [FUNC_W-1:0] FUNC_CREATE   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_DESTROY  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_YIELD    = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_BLOCK    = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_UNBLOCK  = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_SET_PRIO = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_REPORT   = 3'd6;

   localparam logic [1:0] ST_DEAD    = 2'd0;
   localparam logic [1:0] ST_READY   = 2'd1;
   localparam logic [1:0] ST_RUNNING = 2'd2;
   localparam logic [1:0] ST_BLOCKED = 2'd3;

   localparam logic [1:0] LV_HIGH      = 2'b01;
   localparam logic [1:0] LV_NORMAL    = 2'b00;
   localparam logic [1:0] LV_LOW       = 2'b11;
   localparam logic [1:0] PRIO_INVALID = 2'b10;

   localparam int LEVELS = 3;
   localparam logic [1:0] LEVEL_ORDER [LEVELS] = '{LV_HIGH, LV_NORMAL, LV_LOW};

   localparam logic [WAIT_W-1:0] WAIT_NONE = 16'hFFFF;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef struct packed {
      logic [1:0]        state;
      logic [1:0]        level;
      logic [ADDR_W-1:0] entry;
      logic [WAIT_W-1:0] wait_obj;
   } entry_type;

   typedef struct packed {
      logic      we_state;
      logic      we_level;
      logic      we_entry;
      logic      we_wait;
      entry_type data;
   } tbl_wr_type;

   typedef struct packed {
      logic               status;
      logic               thread_found;
      logic [INDEX_W-1:0] thread_index;
      logic [ADDR_W-1:0]  thread_entry;
      logic [COUNT_W-1:0] created_threads;
      logic [COUNT_W-1:0] ready_threads;
      logic [COUNT_W-1:0] blocked_threads;
      logic [ADDR_W-1:0]  switch_total;
   } rsp_payload_type;

endpackage

// ----- rtl/trrs_if.sv -----
// ----------------------------------------------------------------------------
// Three-level round-robin scheduler channels
// Command and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface trrs_req_if;
   logic                              valid;
   logic                              ready;
   logic [trrs_pkg::FUNC_W-1:0]       func;
   logic [trrs_pkg::TID_W-1:0]        thread_id;
   logic signed [1:0]                 priority_req;
   logic [trrs_pkg::ADDR_W-1:0]       entry_address;
   logic signed [trrs_pkg::WAIT_W-1:0] wait_object;

   modport source (output valid, func, thread_id, priority_req, entry_address,
                   wait_object, input ready);
   modport sink (input valid, func, thread_id, priority_req, entry_address,
                 wait_object, output ready);
endinterface

interface trrs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         status;
   logic                         thread_found;
   logic [trrs_pkg::INDEX_W-1:0] thread_index;
   logic [trrs_pkg::ADDR_W-1:0]  thread_entry;
   logic [trrs_pkg::COUNT_W-1:0] created_threads;
   logic [trrs_pkg::COUNT_W-1:0] ready_threads;
   logic [trrs_pkg::COUNT_W-1:0] blocked_threads;
   logic [trrs_pkg::ADDR_W-1:0]  switch_total;

   modport source (output valid, status, thread_found, thread_index, thread_entry,
                   created_threads, ready_threads, blocked_threads, switch_total,
                   input ready);
   modport sink (input valid, status, thread_found, thread_index, thread_entry,
                 created_threads, ready_threads, blocked_threads, switch_total,
                 output ready);
endinterface

// ----- rtl/three_level_round_robin_scheduler_top.sv -----
// The scheduler takes one command transaction at a time and returns one result
// transaction for it. Create, set priority, report and unknown commands finish
// in the execute step; destroy, block and unblock add one read of the thread
// table, accepted or not. A yield scans the thread table memory one slot per cycle
// from the slot after the current thread (slot 0 when none is current) and checks
// the last slot read; when it picks a thread, the picked slot is then read for its
// entry address and the states are written back, and when no thread is ready it
// ends with the scan. A new command is accepted in the cycle after the previous
// result has entered the output register. After reset the table needs no clearing
// pass: the contents of slots beyond the created count are never used.
// ----------------------------------------------------------------------------
// Three-level round-robin scheduler
// Thread table, command sequencer and result register.
// ----------------------------------------------------------------------------
module three_level_round_robin_scheduler_top #(
   parameter int THREADS = trrs_pkg::THREADS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   trrs_req_if.sink   req_ch,
   trrs_rsp_if.source rsp_ch
);

   localparam int IDX_W = $clog2(THREADS);

   logic [IDX_W-1:0]          tbl_wr_addr;
   trrs_pkg::tbl_wr_type      tbl_wr;
   logic [IDX_W-1:0]          tbl_rd_addr;
   trrs_pkg::entry_type       tbl_rd_data;
   logic                      res_valid;
   logic                      res_ready;
   trrs_pkg::rsp_payload_type res;

   trrs_table #(
      .THREADS (THREADS)
   ) u_table (
      .clock   (clock),
      .wr_addr (tbl_wr_addr),
      .wr      (tbl_wr),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   trrs_ctrl #(
      .THREADS (THREADS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .tbl_wr_addr (tbl_wr_addr),
      .tbl_wr      (tbl_wr),
      .tbl_rd_addr (tbl_rd_addr),
      .tbl_rd_data (tbl_rd_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   trrs_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ----- rtl/trrs_table.sv -----
// ----------------------------------------------------------------------------
// Thread table memory
// One write port with per-field enables, one read port with registered data.
// ----------------------------------------------------------------------------
module trrs_table #(
   parameter int THREADS = trrs_pkg::THREADS_DEFAULT
) (
   input  logic                       clock,
   input  logic [$clog2(THREADS)-1:0] wr_addr,
   input  trrs_pkg::tbl_wr_type       wr,
   input  logic [$clog2(THREADS)-1:0] rd_addr,
   output trrs_pkg::entry_type        rd_data
);

   trrs_pkg::entry_type mem [THREADS];
   trrs_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.we_state) begin
         mem[wr_addr].state <= wr.data.state;
      end
      if (wr.we_level) begin
         mem[wr_addr].level <= wr.data.level;
      end
      if (wr.we_entry) begin
         mem[wr_addr].entry <= wr.data.entry;
      end
      if (wr.we_wait) begin
         mem[wr_addr].wait_obj <= wr.data.wait_obj;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/trrs_ctrl.sv -----
// ----------------------------------------------------------------------------
// Scheduler controller
// Command sequencer, table scan, counters and current-thread tracking.
// ----------------------------------------------------------------------------
module trrs_ctrl #(
   parameter int THREADS = trrs_pkg::THREADS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   trrs_req_if.sink                   req_ch,
   output logic [$clog2(THREADS)-1:0] tbl_wr_addr,
   output trrs_pkg::tbl_wr_type       tbl_wr,
   output logic [$clog2(THREADS)-1:0] tbl_rd_addr,
   input  trrs_pkg::entry_type        tbl_rd_data,
   output logic                       res_valid,
   input  logic                       res_ready,
   output trrs_pkg::rsp_payload_type  res
);

   localparam int IDX_W = $clog2(THREADS);
   localparam int CNT_W = $clog2(THREADS + 1);
   localparam int CMP_W = (CNT_W > trrs_pkg::TID_W) ? CNT_W : trrs_pkg::TID_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_CHECK,
      S_SCAN,
      S_PICK,
      S_FIXUP,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [trrs_pkg::FUNC_W-1:0] func_ff, func_in;
   logic [trrs_pkg::TID_W-1:0]  tid_ff, tid_in;
   logic [1:0]                  prio_ff, prio_in;
   logic [trrs_pkg::ADDR_W-1:0] entry_ff, entry_in;
   logic [trrs_pkg::WAIT_W-1:0] wait_ff, wait_in;

   logic [CNT_W-1:0] created_ff, created_in;
   logic [CNT_W-1:0] ready_cnt_ff, ready_cnt_in;
   logic [CNT_W-1:0] blocked_cnt_ff, blocked_cnt_in;
   logic             cur_valid_ff, cur_valid_in;
   logic [IDX_W-1:0] cur_idx_ff, cur_idx_in;
   logic [trrs_pkg::ADDR_W-1:0] switch_ff, switch_in;

   logic [IDX_W-1:0] scan_addr_ff, scan_addr_in;
   logic [CNT_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic [IDX_W-1:0] scan_tag_ff, scan_tag_in;
   logic             scan_vld_ff, scan_vld_in;
   logic [trrs_pkg::LEVELS-1:0] fnd_ff, fnd_in;
   logic [IDX_W-1:0] fidx_ff [trrs_pkg::LEVELS];
   logic [IDX_W-1:0] fidx_in [trrs_pkg::LEVELS];
   logic [IDX_W-1:0] pick_ff, pick_in;

   logic                         res_status_ff, res_status_in;
   logic                         res_found_ff, res_found_in;
   logic [trrs_pkg::INDEX_W-1:0] res_index_ff, res_index_in;
   logic [trrs_pkg::ADDR_W-1:0]  res_entry_ff, res_entry_in;

   logic [CMP_W-1:0] tid_ext;
   logic             in_range;
   logic [IDX_W-1:0] tid_idx;
   logic             cur_is_tid;
   logic             table_full;
   logic [CNT_W-1:0] cur_next;
   logic [CNT_W-1:0] scan_next;
   logic [1:0]       old_state;
   logic             pick_got;
   logic [IDX_W-1:0] pick_sel;

   assign tid_ext    = CMP_W'(tid_ff);
   assign in_range   = tid_ext < CMP_W'(created_ff);
   assign tid_idx    = tid_ext[IDX_W-1:0];
   assign cur_is_tid = cur_valid_ff && (cur_idx_ff == tid_idx);
   assign table_full = created_ff == CNT_W'(THREADS);
   assign cur_next   = CNT_W'(cur_idx_ff) + CNT_W'(1);
   assign scan_next  = CNT_W'(scan_addr_ff) + CNT_W'(1);
   assign old_state  = tbl_rd_data.state;
   assign pick_got   = |fnd_ff;

   always_comb begin
      if (fnd_ff[0]) begin
         pick_sel = fidx_ff[0];
      end else if (fnd_ff[1]) begin
         pick_sel = fidx_ff[1];
      end else begin
         pick_sel = fidx_ff[2];
      end
   end

   always_comb begin
      state_in       = state_ff;
      func_in        = func_ff;
      tid_in         = tid_ff;
      prio_in        = prio_ff;
      entry_in       = entry_ff;
      wait_in        = wait_ff;
      created_in     = created_ff;
      ready_cnt_in   = ready_cnt_ff;
      blocked_cnt_in = blocked_cnt_ff;
      cur_valid_in   = cur_valid_ff;
      cur_idx_in     = cur_idx_ff;
      switch_in      = switch_ff;
      scan_addr_in   = scan_addr_ff;
      scan_cnt_in    = scan_cnt_ff;
      scan_tag_in    = scan_tag_ff;
      scan_vld_in    = scan_vld_ff;
      fnd_in         = fnd_ff;
      fidx_in        = fidx_ff;
      pick_in        = pick_ff;
      res_status_in  = res_status_ff;
      res_found_in   = res_found_ff;
      res_index_in   = res_index_ff;
      res_entry_in   = res_entry_ff;
      tbl_wr_addr    = '0;
      tbl_wr         = '0;
      tbl_rd_addr    = '0;
      res_valid      = 1'b0;
      req_ch.ready   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               func_in  = req_ch.func;
               tid_in   = req_ch.thread_id;
               prio_in  = req_ch.priority_req;
               entry_in = req_ch.entry_address;
               wait_in  = req_ch.wait_object;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            res_status_in = trrs_pkg::STATUS_OK;
            res_found_in  = 1'b0;
            res_index_in  = '0;
            res_entry_in  = '0;
            state_in      = S_DONE;
            unique case (func_ff) inside
               trrs_pkg::FUNC_CREATE: begin
                  if (table_full) begin
                     res_status_in = trrs_pkg::STATUS_REJECT;
                  end else begin
                     tbl_wr_addr              = created_ff[IDX_W-1:0];
                     tbl_wr.we_state          = 1'b1;
                     tbl_wr.we_level          = 1'b1;
                     tbl_wr.we_entry          = 1'b1;
                     tbl_wr.we_wait           = 1'b1;
                     tbl_wr.data.state        = trrs_pkg::ST_READY;
                     tbl_wr.data.level        = (prio_ff == trrs_pkg::PRIO_INVALID) ?
                                                trrs_pkg::LV_NORMAL : prio_ff;
                     tbl_wr.data.entry        = entry_ff;
                     tbl_wr.data.wait_obj     = trrs_pkg::WAIT_NONE;
                     created_in               = created_ff + CNT_W'(1);
                     ready_cnt_in             = ready_cnt_ff + CNT_W'(1);
                     res_found_in             = 1'b1;
                     res_index_in             = trrs_pkg::INDEX_W'(created_ff);
                     res_entry_in             = entry_ff;
                  end
               end
               trrs_pkg::FUNC_DESTROY, trrs_pkg::FUNC_BLOCK, trrs_pkg::FUNC_UNBLOCK: begin
                  tbl_rd_addr = tid_idx;
                  state_in    = S_CHECK;
               end
               trrs_pkg::FUNC_SET_PRIO: begin
                  if (!in_range || prio_ff == trrs_pkg::PRIO_INVALID) begin
                     res_status_in = trrs_pkg::STATUS_REJECT;
                  end else begin
                     tbl_wr_addr       = tid_idx;
                     tbl_wr.we_level   = 1'b1;
                     tbl_wr.data.level = prio_ff;
                  end
               end
               trrs_pkg::FUNC_YIELD: begin
                  fnd_in      = '0;
                  scan_cnt_in = '0;
                  scan_vld_in = 1'b0;
                  if (cur_valid_ff && cur_next != created_ff) begin
                     scan_addr_in = cur_next[IDX_W-1:0];
                  end else begin
                     scan_addr_in = '0;
                  end
                  state_in = S_SCAN;
               end
               trrs_pkg::FUNC_REPORT: begin
                  res_status_in = trrs_pkg::STATUS_OK;
               end
               default: begin
                  res_status_in = trrs_pkg::STATUS_REJECT;
               end
            endcase
         end

         S_CHECK: begin
            state_in = S_DONE;
            unique case (func_ff)
               trrs_pkg::FUNC_DESTROY: begin
                  if (!in_range || old_state == trrs_pkg::ST_DEAD) begin
                     res_status_in = trrs_pkg::STATUS_REJECT;
                  end else begin
                     tbl_wr_addr          = tid_idx;
                     tbl_wr.we_state      = 1'b1;
                     tbl_wr.we_wait       = 1'b1;
                     tbl_wr.data.state    = trrs_pkg::ST_DEAD;
                     tbl_wr.data.wait_obj = trrs_pkg::WAIT_NONE;
                     if (old_state == trrs_pkg::ST_READY) begin
                        ready_cnt_in = ready_cnt_ff - CNT_W'(1);
                     end
                     if (old_state == trrs_pkg::ST_BLOCKED) begin
                        blocked_cnt_in = blocked_cnt_ff - CNT_W'(1);
                     end
                     if (cur_is_tid) begin
                        cur_valid_in = 1'b0;
                     end
                  end
               end
               trrs_pkg::FUNC_BLOCK: begin
                  if (!in_range || old_state == trrs_pkg::ST_DEAD) begin
                     res_status_in = trrs_pkg::STATUS_REJECT;
                  end else begin
                     tbl_wr_addr          = tid_idx;
                     tbl_wr.we_state      = 1'b1;
                     tbl_wr.we_wait       = 1'b1;
                     tbl_wr.data.state    = trrs_pkg::ST_BLOCKED;
                     tbl_wr.data.wait_obj = wait_ff;
                     if (old_state == trrs_pkg::ST_READY) begin
                        ready_cnt_in = ready_cnt_ff - CNT_W'(1);
                     end
                     if (old_state != trrs_pkg::ST_BLOCKED) begin
                        blocked_cnt_in = blocked_cnt_ff + CNT_W'(1);
                     end
                     if (cur_is_tid) begin
                        cur_valid_in = 1'b0;
                     end
                  end
               end
               default: begin
                  if (!in_range || old_state != trrs_pkg::ST_BLOCKED) begin
                     res_status_in = trrs_pkg::STATUS_REJECT;
                  end else begin
                     tbl_wr_addr          = tid_idx;
                     tbl_wr.we_state      = 1'b1;
                     tbl_wr.we_wait       = 1'b1;
                     tbl_wr.data.state    = trrs_pkg::ST_READY;
                     tbl_wr.data.wait_obj = trrs_pkg::WAIT_NONE;
                     ready_cnt_in         = ready_cnt_ff + CNT_W'(1);
                     blocked_cnt_in       = blocked_cnt_ff - CNT_W'(1);
                  end
               end
            endcase
         end

         S_SCAN: begin
            // The running thread counts as ready: it is put back to ready after the pick if another thread wins.
            if (scan_vld_ff && (tbl_rd_data.state == trrs_pkg::ST_READY ||
                                tbl_rd_data.state == trrs_pkg::ST_RUNNING)) begin
               for (int r = 0; r < trrs_pkg::LEVELS; r++) begin
                  if (!fnd_ff[r] && tbl_rd_data.level == trrs_pkg::LEVEL_ORDER[r]) begin
                     fnd_in[r]  = 1'b1;
                     fidx_in[r] = scan_tag_ff;
                  end
               end
            end
            if (scan_cnt_ff < created_ff) begin
               tbl_rd_addr = scan_addr_ff;
               scan_tag_in = scan_addr_ff;
               scan_vld_in = 1'b1;
               scan_cnt_in = scan_cnt_ff + CNT_W'(1);
               if (scan_next == created_ff) begin
                  scan_addr_in = '0;
               end else begin
                  scan_addr_in = scan_next[IDX_W-1:0];
               end
            end else begin
               scan_vld_in = 1'b0;
               state_in    = S_PICK;
            end
         end

         S_PICK: begin
            if (pick_got) begin
               tbl_rd_addr       = pick_sel;
               tbl_wr_addr       = pick_sel;
               tbl_wr.we_state   = 1'b1;
               tbl_wr.data.state = trrs_pkg::ST_RUNNING;
               pick_in           = pick_sel;
               state_in          = S_FIXUP;
            end else begin
               cur_valid_in = 1'b0;
               cur_idx_in   = '0;
               state_in     = S_DONE;
            end
         end

         S_FIXUP: begin
            if (cur_valid_ff && cur_idx_ff != pick_ff) begin
               tbl_wr_addr       = cur_idx_ff;
               tbl_wr.we_state   = 1'b1;
               tbl_wr.data.state = trrs_pkg::ST_READY;
            end
            if (!cur_valid_ff) begin
               ready_cnt_in = ready_cnt_ff - CNT_W'(1);
            end
            if (!cur_valid_ff || cur_idx_ff != pick_ff) begin
               switch_in = switch_ff + 32'd1;
            end
            cur_valid_in = 1'b1;
            cur_idx_in   = pick_ff;
            res_found_in = 1'b1;
            res_index_in = trrs_pkg::INDEX_W'(pick_ff);
            res_entry_in = tbl_rd_data.entry;
            state_in     = S_DONE;
         end

         S_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         created_ff     <= '0;
         ready_cnt_ff   <= '0;
         blocked_cnt_ff <= '0;
         cur_valid_ff   <= 1'b0;
         cur_idx_ff     <= '0;
         switch_ff      <= '0;
         scan_cnt_ff    <= '0;
         scan_vld_ff    <= 1'b0;
         fnd_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         created_ff     <= created_in;
         ready_cnt_ff   <= ready_cnt_in;
         blocked_cnt_ff <= blocked_cnt_in;
         cur_valid_ff   <= cur_valid_in;
         cur_idx_ff     <= cur_idx_in;
         switch_ff      <= switch_in;
         scan_cnt_ff    <= scan_cnt_in;
         scan_vld_ff    <= scan_vld_in;
         fnd_ff         <= fnd_in;
      end
      func_ff       <= func_in;
      tid_ff        <= tid_in;
      prio_ff       <= prio_in;
      entry_ff      <= entry_in;
      wait_ff       <= wait_in;
      scan_addr_ff  <= scan_addr_in;
      scan_tag_ff   <= scan_tag_in;
      fidx_ff       <= fidx_in;
      pick_ff       <= pick_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_index_ff  <= res_index_in;
      res_entry_ff  <= res_entry_in;
   end

   assign res.status          = res_status_ff;
   assign res.thread_found    = res_found_ff;
   assign res.thread_index    = res_index_ff;
   assign res.thread_entry    = res_entry_ff;
   assign res.created_threads = trrs_pkg::COUNT_W'(created_ff);
   assign res.ready_threads   = trrs_pkg::COUNT_W'(ready_cnt_ff);
   assign res.blocked_threads = trrs_pkg::COUNT_W'(blocked_cnt_ff);
   assign res.switch_total    = switch_ff;

endmodule

// ----- rtl/trrs_rsp_reg.sv -----
// ----------------------------------------------------------------------------
// Result output register
// Holds one result transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
module trrs_rsp_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      res_valid,
   output logic                      res_ready,
   input  trrs_pkg::rsp_payload_type res,
   trrs_rsp_if.source                rsp_ch
);

   logic                      valid_ff, valid_in;
   trrs_pkg::rsp_payload_type data_ff, data_in;

   assign res_ready = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (res_valid && res_ready) begin
         valid_in = 1'b1;
         data_in  = res;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_ch.valid           = valid_ff;
   assign rsp_ch.status          = data_ff.status;
   assign rsp_ch.thread_found    = data_ff.thread_found;
   assign rsp_ch.thread_index    = data_ff.thread_index;
   assign rsp_ch.thread_entry    = data_ff.thread_entry;
   assign rsp_ch.created_threads = data_ff.created_threads;
   assign rsp_ch.ready_threads   = data_ff.ready_threads;
   assign rsp_ch.blocked_threads = data_ff.blocked_threads;
   assign rsp_ch.switch_total    = data_ff.switch_total;

endmodule

// ----- rtl/trrs_checker.sv -----
// ----------------------------------------------------------------------------
// Scheduler port checker
// Concurrent assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "three_level_round_robin_scheduler_top_defines.svh"

module trrs_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_status,
   input logic                         rsp_thread_found,
   input logic [trrs_pkg::INDEX_W-1:0] rsp_thread_index,
   input logic [trrs_pkg::ADDR_W-1:0]  rsp_thread_entry,
   input logic [trrs_pkg::COUNT_W-1:0] rsp_created_threads,
   input logic [trrs_pkg::COUNT_W-1:0] rsp_ready_threads,
   input logic [trrs_pkg::COUNT_W-1:0] rsp_blocked_threads,
   input logic [trrs_pkg::ADDR_W-1:0]  rsp_switch_total
);

   `TRRS_ASSERT_CLK(a_reset_clears_rsp, clock, 1'b0, reset |=> !rsp_valid, "result valid after reset")

   `TRRS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_status, rsp_thread_found, rsp_thread_index, rsp_thread_entry, rsp_created_threads, rsp_ready_threads, rsp_blocked_threads, rsp_switch_total}), "stalled result changed")

   `TRRS_ASSERT(a_reject_not_found, rsp_valid && rsp_status |-> !rsp_thread_found && rsp_thread_index == '0 && rsp_thread_entry == '0, "rejected result names a thread")

   `TRRS_ASSERT(a_counts_bounded, rsp_valid |-> (6'(rsp_ready_threads) + 6'(rsp_blocked_threads) <= 6'(rsp_created_threads)), "thread counts exceed created count")

endmodule

bind three_level_round_robin_scheduler_top trrs_checker u_trrs_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_status          (rsp_ch.status),
   .rsp_thread_found    (rsp_ch.thread_found),
   .rsp_thread_index    (rsp_ch.thread_index),
   .rsp_thread_entry    (rsp_ch.thread_entry),
   .rsp_created_threads (rsp_ch.created_threads),
   .rsp_ready_threads   (rsp_ch.ready_threads),
   .rsp_blocked_threads (rsp_ch.blocked_threads),
   .rsp_switch_total    (rsp_ch.switch_total)
);
